[design/gcode_line_move_parser_top_assert.svh]
// Assertion macros used by the checker file.
`ifndef GCODE_LINE_MOVE_PARSER_TOP_ASSERT_SVH
`define GCODE_LINE_MOVE_PARSER_TOP_ASSERT_SVH

// Same-cycle implication, clocked on aclk, off while in reset.
`define GCLMP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("gclmp check failed");

// Next-cycle implication, clocked on aclk, off while in reset.
`define GCLMP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("gclmp check failed");

`endif

[design/gclmp_pkg.sv]
package gclmp_pkg;

    localparam int CoordBits = 16;
    localparam int DiffW     = CoordBits + 1;
    localparam int WideW     = CoordBits + 5;
    localparam int DeltaW    = 17;
    localparam int LinePosW  = 8;

    localparam logic [LinePosW-1:0] MaxLine   = LinePosW'(128);
    localparam logic [LinePosW-1:0] WordStart = LinePosW'(4);
    localparam logic [LinePosW-1:0] LinePosMax = '1;

    localparam logic [7:0] CharNul   = 8'h00;
    localparam logic [7:0] CharTab   = 8'h09;
    localparam logic [7:0] CharLf    = 8'h0A;
    localparam logic [7:0] CharVt    = 8'h0B;
    localparam logic [7:0] CharFf    = 8'h0C;
    localparam logic [7:0] CharCr    = 8'h0D;
    localparam logic [7:0] CharSpace = 8'h20;
    localparam logic [7:0] CharPlus  = 8'h2B;
    localparam logic [7:0] CharMinus = 8'h2D;
    localparam logic [7:0] Char0     = 8'h30;
    localparam logic [7:0] Char1     = 8'h31;
    localparam logic [7:0] Char9     = 8'h39;
    localparam logic [7:0] CharG     = 8'h47;
    localparam logic [7:0] CharX     = 8'h58;
    localparam logic [7:0] CharY     = 8'h59;

    localparam logic signed [WideW-1:0] CoordMaxW =
        WideW'((64'd1 << (CoordBits - 1)) - 64'd1);
    localparam logic signed [WideW-1:0] CoordMinW = -CoordMaxW - WideW'(1);

    typedef logic signed [CoordBits-1:0] coord_t;
    typedef logic signed [DiffW-1:0]     diff_t;
    typedef logic signed [WideW-1:0]     wide_t;
    typedef logic signed [DeltaW-1:0]    delta_t;

    typedef enum logic [2:0] {
        PH_SEEK   = 3'b001,
        PH_SIGN   = 3'b010,
        PH_DIGITS = 3'b100
    } phase_t;

    typedef enum logic [1:0] {
        FLD_NONE = 2'd0,
        FLD_X    = 2'd1,
        FLD_Y    = 2'd2
    } field_t;

    // Line summary handed from the scanner to the move unit.
    typedef struct packed {
        logic       eol;
        logic       is_g;
        logic [7:0] code_first;
        logic [7:0] code_second;
        coord_t     x_value;
        coord_t     y_value;
    } line_t;

    typedef struct packed {
        logic   valid;
        logic   linear;
        delta_t delta_x;
        delta_t delta_y;
    } move_t;

    function automatic coord_t clamp_coord(input wide_t v);
        wide_t r;
        r = v;
        if (v > CoordMaxW) begin
            r = CoordMaxW;
        end else if (v < CoordMinW) begin
            r = CoordMinW;
        end
        return CoordBits'(r);
    endfunction

    function automatic logic is_eol(input logic [7:0] c);
        return (c == CharLf) || (c == CharCr) || (c == CharNul);
    endfunction

endpackage

[design/gclmp_scan.sv]
module gclmp_scan (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step,
    input  logic [7:0]       char_in,
    output gclmp_pkg::line_t line_o
);
    import gclmp_pkg::*;

    logic [LinePosW-1:0] line_pos_reg, line_pos_next;
    logic                is_g_reg, is_g_next;
    logic [7:0]          code_first_reg, code_first_next;
    logic [7:0]          code_second_reg, code_second_next;
    phase_t              phase_reg, phase_next;
    field_t              field_reg, field_next;
    coord_t              x_reg, x_next;
    coord_t              y_reg, y_next;
    logic                neg_reg, neg_next;
    logic                stopped_reg, stopped_next;

    logic   eol;
    logic   is_digit;
    logic   [3:0] digit;
    wide_t  digit_w;
    wide_t  acc_base;
    wide_t  acc_mul;
    wide_t  acc_sum;
    coord_t acc_new;

    assign eol      = is_eol(char_in);
    assign is_digit = (char_in >= Char0) && (char_in <= Char9);
    assign digit    = 4'(char_in - Char0);
    assign digit_w  = signed'(WideW'(digit));
    assign acc_base = WideW'((field_reg == FLD_X) ? x_reg : y_reg);
    assign acc_mul  = (acc_base <<< 3) + (acc_base <<< 1);
    assign acc_sum  = neg_reg ? (acc_mul - digit_w) : (acc_mul + digit_w);
    assign acc_new  = clamp_coord(acc_sum);

    always_comb begin
        line_pos_next    = line_pos_reg;
        is_g_next        = is_g_reg;
        code_first_next  = code_first_reg;
        code_second_next = code_second_reg;
        phase_next       = phase_reg;
        field_next       = field_reg;
        x_next           = x_reg;
        y_next           = y_reg;
        neg_next         = neg_reg;
        stopped_next     = stopped_reg;
        if (step) begin
            if (eol) begin
                line_pos_next    = '0;
                is_g_next        = 1'b0;
                code_first_next  = '0;
                code_second_next = '0;
                phase_next       = PH_SEEK;
                field_next       = FLD_NONE;
                x_next           = '0;
                y_next           = '0;
                neg_next         = 1'b0;
                stopped_next     = 1'b0;
            end else begin
                if (line_pos_reg != LinePosMax) begin
                    line_pos_next = line_pos_reg + LinePosW'(1);
                end
                if (line_pos_reg < MaxLine) begin
                    if (line_pos_reg == LinePosW'(0)) begin
                        is_g_next = (char_in == CharG);
                    end else if (is_g_reg) begin
                        if (line_pos_reg == LinePosW'(1)) begin
                            code_first_next = char_in;
                        end else if (line_pos_reg == LinePosW'(2)) begin
                            code_second_next = char_in;
                        end else if (line_pos_reg >= WordStart) begin
                            if (char_in == CharSpace) begin
                                phase_next = PH_SEEK;
                            end else if (phase_reg == PH_SEEK) begin
                                // address letter opens a new word
                                neg_next   = 1'b0;
                                phase_next = PH_SIGN;
                                if (char_in == CharX) begin
                                    field_next   = FLD_X;
                                    stopped_next = 1'b0;
                                    x_next       = '0;
                                end else if (char_in == CharY) begin
                                    field_next   = FLD_Y;
                                    stopped_next = 1'b0;
                                    y_next       = '0;
                                end else begin
                                    field_next   = FLD_NONE;
                                    stopped_next = 1'b1;
                                end
                            end else if (!stopped_reg) begin
                                if (is_digit) begin
                                    phase_next = PH_DIGITS;
                                    if (field_reg == FLD_X) begin
                                        x_next = acc_new;
                                    end else begin
                                        y_next = acc_new;
                                    end
                                end else if ((phase_reg == PH_SIGN) &&
                                             ((char_in == CharTab) || (char_in == CharVt) ||
                                              (char_in == CharFf))) begin
                                    // atoi skips this whitespace before the sign
                                end else if ((phase_reg == PH_SIGN) &&
                                             ((char_in == CharPlus) ||
                                              (char_in == CharMinus))) begin
                                    neg_next   = (char_in == CharMinus);
                                    phase_next = PH_DIGITS;
                                end else begin
                                    stopped_next = 1'b1;
                                end
                            end
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_pos_reg    <= '0;
            is_g_reg        <= 1'b0;
            code_first_reg  <= '0;
            code_second_reg <= '0;
            phase_reg       <= PH_SEEK;
            field_reg       <= FLD_NONE;
            x_reg           <= '0;
            y_reg           <= '0;
            neg_reg         <= 1'b0;
            stopped_reg     <= 1'b0;
        end else begin
            line_pos_reg    <= line_pos_next;
            is_g_reg        <= is_g_next;
            code_first_reg  <= code_first_next;
            code_second_reg <= code_second_next;
            phase_reg       <= phase_next;
            field_reg       <= field_next;
            x_reg           <= x_next;
            y_reg           <= y_next;
            neg_reg         <= neg_next;
            stopped_reg     <= stopped_next;
        end
    end

    assign line_o.eol         = eol;
    assign line_o.is_g        = is_g_reg;
    assign line_o.code_first  = code_first_reg;
    assign line_o.code_second = code_second_reg;
    assign line_o.x_value     = x_reg;
    assign line_o.y_value     = y_reg;

endmodule

[design/gclmp_move.sv]
module gclmp_move (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step,
    input  gclmp_pkg::line_t line_i,
    output gclmp_pkg::move_t move_o
);
    import gclmp_pkg::*;

    coord_t pos_x_reg, pos_x_next;
    coord_t pos_y_reg, pos_y_next;
    logic   rel_reg, rel_next;

    logic   g_end;
    logic   code_move;
    diff_t  dx;
    diff_t  dy;

    assign g_end = step && line_i.eol && line_i.is_g;
    assign code_move = (line_i.code_first == Char0) &&
                       ((line_i.code_second == Char0) || (line_i.code_second == Char1));

    assign dx = rel_reg ? DiffW'(line_i.x_value)
                        : DiffW'(line_i.x_value) - DiffW'(pos_x_reg);
    assign dy = rel_reg ? DiffW'(line_i.y_value)
                        : DiffW'(line_i.y_value) - DiffW'(pos_y_reg);

    always_comb begin
        pos_x_next = pos_x_reg;
        pos_y_next = pos_y_reg;
        rel_next   = rel_reg;
        if (g_end) begin
            pos_x_next = clamp_coord(WideW'(pos_x_reg) + WideW'(dx));
            pos_y_next = clamp_coord(WideW'(pos_y_reg) + WideW'(dy));
            // mode switch takes effect after this line's move
            if (line_i.code_first == Char9) begin
                if (line_i.code_second == Char0) begin
                    rel_next = 1'b0;
                end else if (line_i.code_second == Char1) begin
                    rel_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            rel_reg   <= 1'b0;
        end else begin
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
            rel_reg   <= rel_next;
        end
    end

    assign move_o.valid   = g_end && code_move;
    assign move_o.linear  = (line_i.code_second == Char1);
    assign move_o.delta_x = DeltaW'(dx);
    assign move_o.delta_y = DeltaW'(dy);

endmodule

[design/gclmp_out.sv]
module gclmp_out (
    input  logic             aclk,
    input  logic             aresetn,
    input  gclmp_pkg::move_t move_i,
    input  logic             load,
    output logic             out_free,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [39:0]      m_tdata,  // delta_x[16:0], delta_y[33:17], zero pad
    output logic [0:0]       m_tuser   // move_linear
);
    import gclmp_pkg::*;

    logic   valid_reg, valid_next;
    logic   linear_reg;
    delta_t dx_reg;
    delta_t dy_reg;

    assign out_free = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load && move_i.valid) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && move_i.valid) begin
            linear_reg <= move_i.linear;
            dx_reg     <= move_i.delta_x;
            dy_reg     <= move_i.delta_y;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {6'b0, dy_reg, dx_reg};
    assign m_tuser  = linear_reg;

endmodule

[design/gcode_line_move_parser_top.sv]
// G-code move parser: takes one character per request on the s_ side and
// gives one request on the m_ side at the end of each G00 or G01 line, with
// the X/Y pen displacement worked out from the tracked position and the
// G90/G91 mode. A character is registered on entry and handled once the
// output side is free, so the block takes one character per clock; it stalls
// only while a finished move waits on m_tready. A move's m_tvalid is registered
// and rises after the line-end character of its line has been handled.
module gcode_line_move_parser_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // char_in[7:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // delta_x[16:0], delta_y[33:17], zero pad
    output logic [0:0]  m_tuser    // move_linear
);
    import gclmp_pkg::*;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_char_reg;
    logic       out_free;
    logic       step;
    line_t      line;
    move_t      move;

    assign step     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || step;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (step) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_char_reg <= s_tdata;
        end
    end

    gclmp_scan u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .char_in (in_char_reg),
        .line_o  (line)
    );

    gclmp_move u_move (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .line_i  (line),
        .move_o  (move)
    );

    gclmp_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .move_i   (move),
        .load     (step),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

[design/gclmp_checker.sv]
`include "gcode_line_move_parser_top_assert.svh"

module gclmp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // a waiting move must hold still
    `GCLMP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // with nothing waiting at the output the input side never stalls
    `GCLMP_ASSERT_NOW(a_in_free, !m_tvalid, s_tready)

    `GCLMP_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[39:34] == 6'b0)

    // a 16-bit coordinate difference never reaches the 17-bit minimum
    `GCLMP_ASSERT_NOW(a_delta_range, m_tvalid,
        (m_tdata[16:0] != 17'h10000) && (m_tdata[33:17] != 17'h10000))

endmodule

bind gcode_line_move_parser_top gclmp_checker u_gclmp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
